// ===== hdl/sfc_pkg.sv =====
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned ALPHABET   = 256;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned SYM_AW     = $clog2(ALPHABET);
  localparam int unsigned DIST_W     = $clog2(ALPHABET + 1);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_GET  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
    logic [7:0] position;
  } req_t;

  typedef struct packed {
    logic [7:0]  result_symbol;
    logic [31:0] result_count;
    logic        in_range;
    logic [8:0]  distinct_total;
  } rsp_t;

  // Count store port bundle.
  typedef struct packed {
    logic                  rd_en;
    logic [SYM_AW-1:0]     rd_addr;
    logic                  wr_en;
    logic [SYM_AW-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
  } cnt_req_t;

  // First-seen list port bundle.
  typedef struct packed {
    logic              rd_en;
    logic [SYM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SYM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
  } list_req_t;

  // Clamp a count to the 32-bit result field.
  function automatic logic [31:0] out_count(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// ===== hdl/sfc_count_mem.sv =====
`timescale 1ns / 1ps

module sfc_count_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfc_pkg::cnt_req_t              req_i,
  output logic [sfc_pkg::COUNT_BITS-1:0] rdata_o
);
  import sfc_pkg::*;

  logic [COUNT_BITS-1:0] mem_q [ALPHABET];
  logic [ALPHABET-1:0]   vld_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  // Per-entry valid bits stand in for clearing the array after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hdl/sfc_list_mem.sv =====
`timescale 1ns / 1ps

module sfc_list_mem (
  input  logic               clk_i,
  input  sfc_pkg::list_req_t req_i,
  output logic [7:0]         rdata_o
);
  import sfc_pkg::*;

  logic [7:0] mem_q [ALPHABET];
  logic [7:0] rdata_q;

  // Entries are read only below the distinct count, so never before written.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/symbol_frequency_counter_core.sv =====
`timescale 1ns / 1ps

// Byte-frequency table for the front end of a Huffman coder. Each request
// carries an opcode: add bumps the saturating count of a symbol and, on its
// first occurrence, appends the symbol to a first-seen list; get returns a
// symbol's count; read-entry returns the symbol and count at a list position
// with an in-range flag. Every request yields exactly one response, in order.
// Counts live in a 256-entry synchronous RAM with per-entry valid bits, so
// the table is empty right after reset with no clearing pass; the list lives
// in a second RAM. A request is handled by a read-modify-write sequencer one
// at a time: add and get go through the count-read and output states,
// read-entry through list-read, count-read and output (list read, then count
// read), and an out-of-range read-entry or unused opcode straight to output.
// The list-then-count lookup sets this order. A finished response sits in an
// output register; the next request is taken while it waits for downstream.

module symbol_frequency_counter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfc_pkg::rsp_t out_rsp_o
);
  import sfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIST = 4'b0010,
    S_CNT  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  op_q, op_d;
  logic [7:0]  sym_q, sym_d;        // response symbol, also RMW address
  logic [31:0] res_cnt_q, res_cnt_d;
  logic        res_in_q, res_in_d;
  logic [DIST_W-1:0] distinct_q, distinct_d;

  logic        out_valid_q;
  rsp_t        out_rsp_q;
  logic        out_load;

  cnt_req_t              cnt_req;
  logic [COUNT_BITS-1:0] cnt_rdata;
  list_req_t             list_req;
  logic [7:0]            list_rdata;

  logic                  in_fire;
  logic                  sym_ok;
  logic                  pos_ok;
  logic                  cnt_zero;
  logic [COUNT_BITS-1:0] cnt_new;

  sfc_count_mem u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cnt_req),
    .rdata_o (cnt_rdata)
  );

  sfc_list_mem u_list_mem (
    .clk_i   (clk_i),
    .req_i   (list_req),
    .rdata_o (list_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Symbol inside the alphabet; position below the distinct count.
  assign sym_ok = (32'(in_req_i.symbol) < 32'(ALPHABET));
  assign pos_ok = (32'(in_req_i.position) < 32'(distinct_q));

  // Saturating increment of the count just read.
  assign cnt_zero = (cnt_rdata == '0);
  assign cnt_new  = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    sym_d      = sym_q;
    res_cnt_d  = res_cnt_q;
    res_in_d   = res_in_q;
    distinct_d = distinct_q;
    out_load   = 1'b0;
    cnt_req    = '0;
    list_req   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d      = in_req_i.opcode;
          sym_d     = '0;
          res_cnt_d = '0;
          res_in_d  = 1'b0;
          state_d   = S_OUT;
          case (op_e'(in_req_i.opcode))
            OP_ADD, OP_GET: begin
              sym_d = in_req_i.symbol;
              if (sym_ok) begin
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = in_req_i.symbol[SYM_AW-1:0];
                state_d         = S_CNT;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                list_req.rd_en   = 1'b1;
                list_req.rd_addr = in_req_i.position[SYM_AW-1:0];
                res_in_d         = 1'b1;
                state_d          = S_LIST;
              end
            end
            default: begin
              // unused opcode: zero response, table untouched
            end
          endcase
        end
      end

      S_LIST: begin
        // List entry in hand; look up its count next.
        sym_d           = list_rdata;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = list_rdata[SYM_AW-1:0];
        state_d         = S_CNT;
      end

      S_CNT: begin
        if (op_e'(op_q) == OP_ADD) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = sym_q[SYM_AW-1:0];
          cnt_req.wr_data = cnt_new;
          res_cnt_d       = out_count(cnt_new);
          // first occurrence: append to the first-seen list
          if (cnt_zero && (32'(distinct_q) < 32'(ALPHABET))) begin
            list_req.wr_en   = 1'b1;
            list_req.wr_addr = distinct_q[SYM_AW-1:0];
            list_req.wr_data = sym_q;
            distinct_d       = distinct_q + DIST_W'(1);
          end
        end else begin
          res_cnt_d = out_count(cnt_rdata);
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      distinct_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      distinct_q <= distinct_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sym_q     <= sym_d;
    res_cnt_q <= res_cnt_d;
    res_in_q  <= res_in_d;
    if (out_load) begin
      out_rsp_q.result_symbol  <= sym_q;
      out_rsp_q.result_count   <= res_cnt_q;
      out_rsp_q.in_range       <= res_in_q;
      out_rsp_q.distinct_total <= 9'(distinct_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // Distinct count never passes the alphabet size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(distinct_q) <= 32'(ALPHABET))
    else $error("distinct count beyond alphabet");

  // A first occurrence grows the distinct count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT && list_req.wr_en) |=> (distinct_q == $past(distinct_q) + DIST_W'(1)))
    else $error("append did not advance distinct count");

  // Count data is consumed only in the cycle after a count read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT) |-> $past(cnt_req.rd_en))
    else $error("count used without a preceding read");

  // No new request is taken while the sequencer holds a response for output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_load) |=> (state_q == S_OUT))
    else $error("response dropped while output stalled");
`endif

endmodule
